[sv/rkst_pkg.sv]
// rkst_pkg: types, codes and defaults for the reference-counted key slot table
// used by refcounted_key_slot_table; depends on nothing
`default_nettype none

package rkst_pkg;

    // default geometry
    localparam int SLOT_COUNT_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;

    // fixed field widths of the transactions
    localparam int ACTION_W = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int RCOUNT_W = 16;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLOSE  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_CREATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOPAGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FREED    = 3'd5;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic signed [KEY_W-1:0] key;
        logic                    page_available;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [RCOUNT_W-1:0] ref_count;
    } rsp_item_t;

endpackage

`default_nettype wire

[sv/refcounted_key_slot_table.sv]
// refcounted_key_slot_table: key table with per-slot reference counts
// depends on rkst_pkg for transaction types, action and status codes
//
// a command accepted into the command register gets its response in the response register
// throughput: one command per cycle while the response side does not stall; the single
// compare-and-update stage over all slots writes the table at the same edge as the response
// reset: clears all slot valid bits and both stage valids; keys and counts need none
`default_nettype none

module refcounted_key_slot_table #(
    parameter int SLOT_COUNT = rkst_pkg::SLOT_COUNT_DEF,
    parameter int COUNT_BITS = rkst_pkg::COUNT_BITS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cmd_valid,
    output logic                 cmd_stall,
    input  rkst_pkg::cmd_item_t  cmd,
    output logic                 rsp_valid,
    input  wire                  rsp_stall,
    output rkst_pkg::rsp_item_t  rsp
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // slot storage: valid bits reset, keys and counts only read behind a valid bit
    logic [SLOT_COUNT-1:0]          slot_valid_reg;
    logic [rkst_pkg::KEY_W-1:0]     slot_key_reg  [SLOT_COUNT];
    logic [COUNT_BITS-1:0]          slot_refs_reg [SLOT_COUNT];

    // command register
    logic                           stage_valid_reg;
    rkst_pkg::cmd_item_t            stage_cmd_reg;

    // response register
    logic                           rsp_valid_reg;
    rkst_pkg::rsp_item_t            rsp_reg;

    // stage moves forward when the response register is empty or being drained
    logic                           advance;
    logic                           fire;

    // lookup results
    logic [SLOT_COUNT-1:0]          hit_vec;
    logic [SLOT_COUNT-1:0]          hit_oh;
    logic [SLOT_COUNT-1:0]          free_oh;
    logic                           any_hit;
    logic                           any_free;
    logic [IDX_W-1:0]               hit_idx;
    logic [IDX_W-1:0]               free_idx;
    logic [COUNT_BITS-1:0]          sel_refs;

    // update controls
    logic [SLOT_COUNT-1:0]          target_oh;
    logic                           do_create;
    logic                           do_refs;
    logic                           do_free;
    logic [COUNT_BITS-1:0]          new_refs;

    // response before width fitting
    logic [rkst_pkg::STATUS_W-1:0]  res_status;
    logic [IDX_W-1:0]               res_idx;
    logic [COUNT_BITS-1:0]          res_count;
    logic [IDX_W+rkst_pkg::SLOT_W-1:0]       res_idx_wide;
    logic [COUNT_BITS+rkst_pkg::RCOUNT_W-1:0] res_count_wide;
    rkst_pkg::rsp_item_t            rsp_next;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = stage_valid_reg && advance;
    assign cmd_stall = stage_valid_reg && !advance;

    // parallel key compare, lowest index wins
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            hit_vec[i] = slot_valid_reg[i] &&
                         (slot_key_reg[i] == stage_cmd_reg.key);
        end
    end

    assign hit_oh   = hit_vec & (~hit_vec + {{(SLOT_COUNT-1){1'b0}}, 1'b1});
    assign free_oh  = ~slot_valid_reg & (slot_valid_reg + {{(SLOT_COUNT-1){1'b0}}, 1'b1});
    assign any_hit  = |hit_vec;
    assign any_free = !(&slot_valid_reg);

    // one-hot to index, and count of the hit slot
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        sel_refs = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (hit_oh[i])
            begin
                hit_idx  = hit_idx | IDX_W'(i);
                sel_refs = sel_refs | slot_refs_reg[i];
            end
            if (free_oh[i])
            begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
    end

    // operation decode
    always_comb
    begin
        do_create  = 1'b0;
        do_refs    = 1'b0;
        do_free    = 1'b0;
        new_refs   = sel_refs;
        target_oh  = hit_oh;
        res_status = rkst_pkg::ST_NOTFOUND;
        res_idx    = '0;
        res_count  = '0;
        priority if (stage_cmd_reg.action == rkst_pkg::ACT_CREATE)
        begin
            priority if (any_hit)
            begin
                // existing key: report it, count untouched
                res_status = rkst_pkg::ST_FOUND;
                res_idx    = hit_idx;
                res_count  = sel_refs;
            end
            else if (!any_free)
            begin
                res_status = rkst_pkg::ST_FULL;
            end
            else if (!stage_cmd_reg.page_available)
            begin
                res_status = rkst_pkg::ST_NOPAGE;
            end
            else
            begin
                // claim lowest free slot with one reference
                do_create  = 1'b1;
                target_oh  = free_oh;
                new_refs   = {{(COUNT_BITS-1){1'b0}}, 1'b1};
                res_status = rkst_pkg::ST_CREATED;
                res_idx    = free_idx;
                res_count  = new_refs;
            end
        end
        else if (stage_cmd_reg.action == rkst_pkg::ACT_GET && any_hit)
        begin
            // saturating increment
            do_refs    = 1'b1;
            new_refs   = (&sel_refs) ? sel_refs : sel_refs + 1'b1;
            res_status = rkst_pkg::ST_FOUND;
            res_idx    = hit_idx;
            res_count  = new_refs;
        end
        else if (stage_cmd_reg.action == rkst_pkg::ACT_CLOSE && any_hit)
        begin
            res_idx = hit_idx;
            priority if (sel_refs < COUNT_BITS'(2))
            begin
                // last reference gone (or count already zero): release slot
                do_free    = 1'b1;
                res_status = rkst_pkg::ST_FREED;
            end
            else
            begin
                do_refs    = 1'b1;
                new_refs   = sel_refs - 1'b1;
                res_status = rkst_pkg::ST_FOUND;
                res_count  = new_refs;
            end
        end
        else
        begin
            // unknown action or no matching key
            res_status = rkst_pkg::ST_NOTFOUND;
        end
    end

    // fit index and count to the response field widths
    assign res_idx_wide   = {{rkst_pkg::SLOT_W{1'b0}}, res_idx};
    assign res_count_wide = {{rkst_pkg::RCOUNT_W{1'b0}}, res_count};

    always_comb
    begin
        rsp_next.status    = res_status;
        rsp_next.slot      = res_idx_wide[rkst_pkg::SLOT_W-1:0];
        rsp_next.ref_count = res_count_wide[rkst_pkg::RCOUNT_W-1:0];
    end

    // slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (fire)
        begin
            if (do_create)
            begin
                slot_valid_reg <= slot_valid_reg | target_oh;
            end
            else if (do_free)
            begin
                slot_valid_reg <= slot_valid_reg & ~target_oh;
            end
        end
    end

    // slot keys and counts
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (fire && target_oh[i])
            begin
                if (do_create)
                begin
                    slot_key_reg[i] <= stage_cmd_reg.key;
                end
                if (do_create || do_refs)
                begin
                    slot_refs_reg[i] <= new_refs;
                end
            end
        end
    end

    // command register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            stage_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            stage_cmd_reg <= cmd;
        end
    end

    // response register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a key never occupies two valid slots
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
        else $error("key matches more than one valid slot");

    // a successful create adds exactly one valid slot
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && do_create |=>
        $countones(slot_valid_reg) == $countones($past(slot_valid_reg)) + 1)
        else $error("create did not claim exactly one slot");

    // a freed slot is reported with a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == rkst_pkg::ST_FREED |-> rsp.ref_count == '0)
        else $error("freed slot reported with nonzero count");

    // failures name no slot and no count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == rkst_pkg::ST_FULL ||
                      rsp.status == rkst_pkg::ST_NOPAGE ||
                      rsp.status == rkst_pkg::ST_NOTFOUND)
        |-> rsp.slot == '0 && rsp.ref_count == '0)
        else $error("failed operation reported a slot or count");

endmodule

`default_nettype wire

[test/tb_refcounted_key_slot_table.sv]
// tb_refcounted_key_slot_table: self-checking testbench for the refcounted key slot table
// depends on rkst_pkg (transaction types, action and status codes) and the
// refcounted_key_slot_table rtl

module tb_refcounted_key_slot_table;

    // action code the block ignores
    localparam logic [rkst_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [rkst_pkg::RCOUNT_W-1:0] REFS_MAX   = {rkst_pkg::RCOUNT_W{1'b1}};
    localparam int NSLOTS      = rkst_pkg::SLOT_COUNT_DEF;
    localparam int RANDOM_CMDS = 800;
    localparam int POOL_SIZE   = 20;
    localparam int BURST_GETS  = 40;

    // shadow copy of the slot table plus the queue of responses it predicts
    class slot_table_scoreboard;
        bit                            live[NSLOTS];
        logic [rkst_pkg::KEY_W-1:0]    slot_keys[NSLOTS];
        logic [rkst_pkg::RCOUNT_W-1:0] slot_refs[NSLOTS];
        rkst_pkg::rsp_item_t           pending_rsp[$];
        int                            errors;

        function new();
            for (int i = 0; i < NSLOTS; i++)
            begin
                live[i]      = 1'b0;
                slot_keys[i] = '1;
                slot_refs[i] = '0;
            end
            errors = 0;
        endfunction

        // apply one accepted command to the shadow table
        function void note_command(rkst_pkg::cmd_item_t c);
            int                  hit;
            int                  spare;
            rkst_pkg::rsp_item_t e;
            hit   = -1;
            spare = -1;
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (hit < 0 && live[i] && slot_keys[i] == c.key)
                    hit = i;
                if (spare < 0 && !live[i])
                    spare = i;
            end
            e.status    = rkst_pkg::ST_NOTFOUND;
            e.slot      = '0;
            e.ref_count = '0;
            case (c.action)
                rkst_pkg::ACT_CREATE:
                begin
                    if (hit >= 0)
                    begin
                        e.status    = rkst_pkg::ST_FOUND;
                        e.slot      = rkst_pkg::SLOT_W'(hit);
                        e.ref_count = slot_refs[hit];
                    end
                    else if (spare < 0)
                        e.status = rkst_pkg::ST_FULL;
                    else if (!c.page_available)
                        e.status = rkst_pkg::ST_NOPAGE;
                    else
                    begin
                        live[spare]      = 1'b1;
                        slot_keys[spare] = c.key;
                        slot_refs[spare] = rkst_pkg::RCOUNT_W'(1);
                        e.status         = rkst_pkg::ST_CREATED;
                        e.slot           = rkst_pkg::SLOT_W'(spare);
                        e.ref_count      = rkst_pkg::RCOUNT_W'(1);
                    end
                end
                rkst_pkg::ACT_GET:
                begin
                    if (hit >= 0)
                    begin
                        if (slot_refs[hit] != REFS_MAX)
                            slot_refs[hit] = slot_refs[hit] + 1'b1;
                        e.status    = rkst_pkg::ST_FOUND;
                        e.slot      = rkst_pkg::SLOT_W'(hit);
                        e.ref_count = slot_refs[hit];
                    end
                end
                rkst_pkg::ACT_CLOSE:
                begin
                    if (hit >= 0)
                    begin
                        e.slot = rkst_pkg::SLOT_W'(hit);
                        if (slot_refs[hit] <= 1)
                        begin
                            live[hit]      = 1'b0;
                            slot_keys[hit] = '1;
                            slot_refs[hit] = '0;
                            e.status       = rkst_pkg::ST_FREED;
                        end
                        else
                        begin
                            slot_refs[hit] = slot_refs[hit] - 1'b1;
                            e.status       = rkst_pkg::ST_FOUND;
                            e.ref_count    = slot_refs[hit];
                        end
                    end
                end
                default: ;
            endcase
            pending_rsp.push_back(e);
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
            errors++;
            $display("%0t mismatch on %s: expected %0d, actual %0d",
                     $time, field, exp_v, act_v);
        endfunction

        // compare one accepted response against the oldest prediction
        function void check_response(rkst_pkg::rsp_item_t r);
            rkst_pkg::rsp_item_t e;
            if (pending_rsp.size() == 0)
            begin
                errors++;
                $display("%0t unexpected response: expected none, actual %0d/%0d/%0d",
                         $time, r.status, r.slot, r.ref_count);
                return;
            end
            e = pending_rsp.pop_front();
            if (r.status !== e.status)
                report("status", 32'(e.status), 32'(r.status));
            if (r.slot !== e.slot)
                report("slot", 32'(e.slot), 32'(r.slot));
            if (r.ref_count !== e.ref_count)
                report("ref_count", 32'(e.ref_count), 32'(r.ref_count));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    rkst_pkg::cmd_item_t cmd;
    logic                rsp_valid;
    logic                rsp_stall;
    rkst_pkg::rsp_item_t rsp;

    slot_table_scoreboard sb;

    // calm: a stretch where neither side idles; fast: the back-to-back count burst
    bit calm;
    bit fast;

    logic [rkst_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

    refcounted_key_slot_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // per-transaction idle draw shared by the sender and the receiver
    function automatic int pick_wait();
        return (calm || fast) ? 0 : $urandom_range(0, 8);
    endfunction

    // drive one command transaction and hold it until the block takes it;
    // valid stays high afterwards so back-to-back commands need no bubble
    task automatic issue(input logic [rkst_pkg::ACTION_W-1:0] act,
                         input logic [rkst_pkg::KEY_W-1:0] k, input bit pg);
        rkst_pkg::cmd_item_t c;
        int                  gap;
        c.action         = act;
        c.key            = k;
        c.page_available = pg;
        gap = pick_wait();
        repeat (gap)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        sb.note_command(c);
    endtask

    // drop valid and hold off until every predicted response has come back
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // response side: random stall before each transaction, then take it
    initial
    begin
        int w;
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            w = pick_wait();
            if (w > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (w) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            sb.check_response(rsp);
        end
    end

    // main sequence
    initial
    begin
        int r;
        logic [rkst_pkg::KEY_W-1:0] k;
        sb        = new();
        calm      = 1'b0;
        fast      = 1'b0;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table lookups, all-ones key as an ordinary key
        issue(rkst_pkg::ACT_GET,    32'hFFFF_FFFF, 1'b1);
        issue(rkst_pkg::ACT_CLOSE,  32'h0000_0000, 1'b0);
        issue(rkst_pkg::ACT_CREATE, 32'hFFFF_FFFF, 1'b1);
        // create on existing key ignores page availability
        issue(rkst_pkg::ACT_CREATE, 32'hFFFF_FFFF, 1'b0);
        // free slot but no page: table untouched
        issue(rkst_pkg::ACT_CREATE, 32'h8000_0000, 1'b0);
        issue(rkst_pkg::ACT_CREATE, 32'h8000_0000, 1'b1);
        issue(rkst_pkg::ACT_CREATE, 32'h7FFF_FFFF, 1'b1);
        issue(rkst_pkg::ACT_GET,    32'h7FFF_FFFF, 1'b0);
        // close with refs left, then close to zero frees the slot
        issue(rkst_pkg::ACT_CLOSE,  32'h7FFF_FFFF, 1'b1);
        issue(rkst_pkg::ACT_CLOSE,  32'h7FFF_FFFF, 1'b1);
        // unused action code is a no-op
        issue(ACT_UNUSED,           32'hFFFF_FFFF, 1'b1);
        issue(rkst_pkg::ACT_GET,    32'h7FFF_FFFF, 1'b1);
        // fill the freed slot and every other one
        for (int i = 1; i <= 14; i++)
            issue(rkst_pkg::ACT_CREATE, 32'h1111_1111 * i, 1'b1);
        // full table wins over page availability
        issue(rkst_pkg::ACT_CREATE, 32'h5A5A_5A5A, 1'b1);
        issue(rkst_pkg::ACT_CREATE, 32'h5A5A_5A5A, 1'b0);
        issue(rkst_pkg::ACT_CLOSE,  32'hFFFF_FFFF, 1'b0);

        // let the pipeline empty before the burst
        wait_drained();

        // back-to-back burst: count climbs, then walks all the way back
        // down until the slot is freed
        fast = 1'b1;
        repeat (BURST_GETS) issue(rkst_pkg::ACT_GET, 32'h8000_0000, 1'b1);
        repeat (BURST_GETS + 1) issue(rkst_pkg::ACT_CLOSE, 32'h8000_0000, 1'b0);
        fast = 1'b0;
        wait_drained();

        // random part over a key pool slightly larger than the table,
        // so creates hit, miss, fill and overflow
        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'h8000_0000;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            k = ($urandom_range(0, 19) == 0) ? $urandom
                                             : key_pool[$urandom_range(0, POOL_SIZE - 1)];
            r = $urandom_range(0, 99);
            if (r < 38)
                issue(rkst_pkg::ACT_CREATE, k, $urandom_range(0, 9) != 0);
            else if (r < 62)
                issue(rkst_pkg::ACT_GET, k, 1'($urandom_range(0, 1)));
            else if (r < 92)
                issue(rkst_pkg::ACT_CLOSE, k, 1'($urandom_range(0, 1)));
            else if (r < 96)
                issue(ACT_UNUSED, k, 1'($urandom_range(0, 1)));
            else
                issue(rkst_pkg::ACT_CREATE, $urandom, 1'($urandom_range(0, 1)));
        end
        calm = 1'b0;

        // drain, then give the two-stage pipeline time to show stray responses
        wait_drained();
        repeat (6) @(posedge clk);

        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #200000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
